/* rtl/core/cbm_pkg.sv */
// Shared types and constants of the cartridge bank mapper.
`default_nettype none

package cbm_pkg;

	// Operation codes of an input item
	localparam logic OP_CPU_WRITE = 1'b0;
	localparam logic OP_TICK      = 1'b1;

	// Register space decode
	localparam logic [14:0] ADDR_MASK    = 15'h7003;
	localparam logic [14:0] ADDR_CHR0    = 15'h6000;
	localparam logic [14:0] ADDR_CHR1    = 15'h6001;
	localparam logic [14:0] ADDR_CHR2    = 15'h6002;
	localparam logic [14:0] ADDR_CHR3    = 15'h6003;
	localparam logic [14:0] ADDR_PRG0    = 15'h7000;
	localparam logic [14:0] ADDR_PRG1    = 15'h7001;
	localparam logic [14:0] ADDR_IRQ_ACK = 15'h7002;
	localparam logic [14:0] ADDR_IRQ_EN  = 15'h7003;

	// Configuration register indexes
	localparam logic CFG_CHR_ROM_UNITS = 1'b0;
	localparam logic CFG_PRG_ROM_UNITS = 1'b1;

	localparam logic [7:0] PRG_UNITS_RESET = 8'd2;

	localparam int CHR_SLOTS = 4;
	localparam int DIV_STEPS = 3;
	localparam int STEP_W    = 2;
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

	typedef struct packed {
		logic        operation;
		logic [14:0] cpu_address;
		logic [7:0]  write_data;
	} cbm_item_t;

	typedef struct packed {
		logic [8:0] chr_page_slot0;
		logic [8:0] chr_page_slot1;
		logic [8:0] chr_page_slot2;
		logic [8:0] chr_page_slot3;
		logic [7:0] prg_page_8000;
		logic [7:0] prg_page_a000;
		logic [8:0] prg_page_c000;
		logic [8:0] prg_page_e000;
		logic       irq_line;
	} cbm_result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_EMIT
	} cbm_state_t;

	typedef struct packed {
		logic              apply;
		logic              div_step;
		logic [STEP_W-1:0] step_idx;
		logic              load_out;
	} cbm_cmd_t;

	typedef struct packed {
		logic out_free;
	} cbm_sts_t;

endpackage

`default_nettype wire

/* rtl/core/cbm_intf.sv */
// Handshake channels for input items and result items.
`default_nettype none

interface cbm_item_if import cbm_pkg::*; ();
	logic      valid;
	logic      ready;
	cbm_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface cbm_result_if import cbm_pkg::*; ();
	logic        valid;
	logic        ready;
	cbm_result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/core/cbm_ctrl.sv */
// Controller: sequences accept, CHR modulo steps and result load.
`default_nettype none

module cbm_ctrl import cbm_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     item_valid,
	output logic          item_ready,
	input  wire cbm_sts_t sts,
	output cbm_cmd_t      cmd
);

	cbm_state_t        state_q;
	cbm_state_t        state_next;
	logic [STEP_W-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_next;
			if (state_q == ST_DIVIDE) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) state_next = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (step_q == STEP_LAST) state_next = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		item_ready   = 1'b0;
		cmd.apply    = 1'b0;
		cmd.div_step = 1'b0;
		cmd.step_idx = step_q;
		cmd.load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				cmd.apply  = item_valid;
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
			end
			ST_EMIT: begin
				cmd.load_out = sts.out_free;
			end
			default: ;
		endcase
	end

	// Every accepted item runs the full modulo sequence
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |=> state_q == ST_DIVIDE && step_q == '0)
		else $error("accepted item did not start the modulo sequence");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIVIDE |-> step_q <= STEP_LAST)
		else $error("modulo step counter overran");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> state_q == ST_IDLE)
		else $error("result load did not return to idle");

endmodule

`default_nettype wire

/* rtl/core/cbm_datapath.sv */
// Datapath: bank registers, IRQ counter, CHR modulo unit and result register.
`default_nettype none

module cbm_datapath import cbm_pkg::*; #(
	parameter int IRQ_LINE_COUNT = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire cbm_item_t   item,
	input  wire cbm_cmd_t    cmd,
	output cbm_sts_t         sts,
	input  wire logic        res_ready,
	output logic             res_valid,
	output cbm_result_t      res
);

	localparam logic [3:0] LINE_COUNT = 4'(IRQ_LINE_COUNT);

	logic [7:0] chr_units_q;
	logic [7:0] prg_units_q;
	logic [7:0] chr_bank_q [CHR_SLOTS];
	logic [7:0] prg_bank_q [2];
	logic       irq_enabled_q;
	logic [3:0] count_q;
	logic       irq_pending_q;
	logic [7:0] rem_q [CHR_SLOTS];
	logic [7:0] rem_next [CHR_SLOTS];
	logic       res_valid_q;
	cbm_result_t res_q;
	logic [14:0] dec_addr;
	logic [8:0]  prg8k;
	logic [8:0]  chr_base [CHR_SLOTS];

	assign dec_addr = item.cpu_address & ADDR_MASK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chr_units_q <= '0;
			prg_units_q <= PRG_UNITS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CHR_ROM_UNITS: chr_units_q <= cfg_data;
				CFG_PRG_ROM_UNITS: prg_units_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHR_SLOTS; i++) chr_bank_q[i] <= '0;
			prg_bank_q[0] <= '0;
			prg_bank_q[1] <= '0;
			irq_enabled_q <= 1'b0;
			count_q       <= '0;
			irq_pending_q <= 1'b0;
		end else if (cmd.apply) begin
			if (item.operation == OP_CPU_WRITE) begin
				unique case (dec_addr)
					ADDR_CHR0: chr_bank_q[0] <= item.write_data;
					ADDR_CHR1: chr_bank_q[1] <= item.write_data;
					ADDR_CHR2: chr_bank_q[2] <= item.write_data;
					ADDR_CHR3: chr_bank_q[3] <= item.write_data;
					ADDR_PRG0: prg_bank_q[0] <= item.write_data;
					ADDR_PRG1: prg_bank_q[1] <= item.write_data;
					ADDR_IRQ_ACK: begin
						irq_enabled_q <= 1'b0;
						count_q       <= '0;
						irq_pending_q <= 1'b0;
					end
					ADDR_IRQ_EN: begin
						irq_enabled_q <= 1'b1;
						irq_pending_q <= 1'b0;
					end
					default: ;
				endcase
			end else if (irq_enabled_q && count_q < LINE_COUNT) begin
				count_q <= count_q + 4'd1;
				if (count_q + 4'd1 == LINE_COUNT) irq_pending_q <= 1'b1;
			end
		end
	end

	// Restoring remainder of (bank / 4) by chr_units, two quotient bits a step
	always_comb begin
		logic [1:0] pair;
		logic [8:0] r1;
		logic [8:0] r2;
		for (int i = 0; i < CHR_SLOTS; i++) begin
			unique case (cmd.step_idx)
				2'd0:    pair = chr_bank_q[i][7:6];
				2'd1:    pair = chr_bank_q[i][5:4];
				default: pair = chr_bank_q[i][3:2];
			endcase
			r1 = {rem_q[i], pair[1]};
			if (r1 >= {1'b0, chr_units_q}) r1 = r1 - {1'b0, chr_units_q};
			r2 = {r1[7:0], pair[0]};
			if (r2 >= {1'b0, chr_units_q}) r2 = r2 - {1'b0, chr_units_q};
			rem_next[i] = r2[7:0];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < CHR_SLOTS; i++) begin
			if (cmd.apply) begin
				rem_q[i] <= '0;
			end else if (cmd.div_step) begin
				rem_q[i] <= rem_next[i];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < CHR_SLOTS; i++) begin
			if (chr_units_q == '0) begin
				chr_base[i] = 9'(2 * i);
			end else begin
				chr_base[i] = {rem_q[i][5:0], chr_bank_q[i][1:0], 1'b0};
			end
		end
	end

	assign prg8k = {prg_units_q, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res_q.chr_page_slot0 <= chr_base[0];
			res_q.chr_page_slot1 <= chr_base[1];
			res_q.chr_page_slot2 <= chr_base[2];
			res_q.chr_page_slot3 <= chr_base[3];
			res_q.prg_page_8000  <= prg_bank_q[0];
			res_q.prg_page_a000  <= prg_bank_q[1];
			res_q.prg_page_c000  <= prg8k - 9'd2;
			res_q.prg_page_e000  <= prg8k - 9'd1;
			res_q.irq_line       <= irq_pending_q;
		end
	end

	assign sts.out_free = !res_valid_q || res_ready;
	assign res_valid    = res_valid_q;
	assign res          = res_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		irq_pending_q |-> count_q == LINE_COUNT)
		else $error("IRQ pending without a full line count");

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LINE_COUNT)
		else $error("line count passed its limit");

	assert property (@(posedge clk) disable iff (!arst_n)
		irq_pending_q |-> irq_enabled_q)
		else $error("IRQ pending while disabled");

endmodule

`default_nettype wire

/* rtl/core/cartridge_bank_mapper_scanline_irq.sv */
// Top level of the cartridge bank mapper with scanline IRQ.
//
//   channel  dir   payload        handshake
//   cmd      in    cbm_item_t     valid/ready
//   res      out   cbm_result_t   valid/ready
//   cfg      in    index, data    cfg_we, no wait
//
// An item passes through the accepting cycle, three steps of the CHR modulo
// unit (two quotient bits per step, four slots side by side) and the result
// load, which waits while the result register is still held by a stalled
// result. The next item is taken in the cycle after the load.
// Reset clears bank registers, IRQ state and sizes (PRG size to 2).
// A stalled result holds in its register; a further item is still accepted
// and waits for the result register before it loads.
`default_nettype none

module cartridge_bank_mapper_scanline_irq import cbm_pkg::*; #(
	parameter int IRQ_LINE_COUNT = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	cbm_item_if.sink        cmd,
	cbm_result_if.source    res,
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [7:0] cfg_data
);

	cbm_cmd_t ctl_cmd;
	cbm_sts_t dp_sts;

	cbm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (cmd.valid),
		.item_ready (cmd.ready),
		.sts        (dp_sts),
		.cmd        (ctl_cmd)
	);

	cbm_datapath #(
		.IRQ_LINE_COUNT (IRQ_LINE_COUNT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (cmd.payload),
		.cmd       (ctl_cmd),
		.sts       (dp_sts),
		.res_ready (res.ready),
		.res_valid (res.valid),
		.res       (res.payload)
	);

endmodule

`default_nettype wire

/* test/cartridge_bank_mapper_scanline_irq_checker.sv */
`timescale 1ns / 1ps
// Mapping predictor and result checker for the cartridge bank mapper.
module cartridge_bank_mapper_scanline_irq_checker import cbm_pkg::*; #(
	parameter int IRQ_LINE_COUNT = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	cbm_item_if        cmd,
	cbm_result_if      res,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	output int         fail_count,
	output int         mappings_due_count
);

	logic [7:0] chr_units;
	logic [7:0] prg_units;
	logic [7:0] chr_banks [CHR_SLOTS];
	logic [7:0] prg_windows [2];
	logic       irq_armed;
	logic [3:0] line_count;
	logic       irq_flag;

	cbm_result_t mappings_due [$];

	function automatic logic [8:0] chr_page_base(int slot);
		if (chr_units == 8'd0)
			return 9'(slot * 2);
		return 9'((int'(chr_banks[slot]) % (int'(chr_units) * 4)) * 2);
	endfunction

	// Apply one item to the mapper state and return the mapping it leaves behind
	function automatic cbm_result_t next_mapping(cbm_item_t it);
		cbm_result_t m;
		logic [8:0]  prg_second_last;
		if (it.operation == OP_CPU_WRITE) begin
			case (it.cpu_address & ADDR_MASK)
				ADDR_CHR0: chr_banks[0] = it.write_data;
				ADDR_CHR1: chr_banks[1] = it.write_data;
				ADDR_CHR2: chr_banks[2] = it.write_data;
				ADDR_CHR3: chr_banks[3] = it.write_data;
				ADDR_PRG0: prg_windows[0] = it.write_data;
				ADDR_PRG1: prg_windows[1] = it.write_data;
				ADDR_IRQ_ACK: begin
					irq_armed  = 1'b0;
					line_count = 4'd0;
					irq_flag   = 1'b0;
				end
				ADDR_IRQ_EN: begin
					// count is kept, so a finished count raises nothing further
					irq_armed = 1'b1;
					irq_flag  = 1'b0;
				end
				default: ;
			endcase
		end else if (irq_armed && line_count < IRQ_LINE_COUNT) begin
			line_count = line_count + 4'd1;
			if (line_count >= IRQ_LINE_COUNT)
				irq_flag = 1'b1;
		end
		// wraps modulo 512 for an empty PRG size
		prg_second_last  = {prg_units, 1'b0} - 9'd2;
		m.chr_page_slot0 = chr_page_base(0);
		m.chr_page_slot1 = chr_page_base(1);
		m.chr_page_slot2 = chr_page_base(2);
		m.chr_page_slot3 = chr_page_base(3);
		m.prg_page_8000  = prg_windows[0];
		m.prg_page_a000  = prg_windows[1];
		m.prg_page_c000  = prg_second_last;
		m.prg_page_e000  = prg_second_last + 9'd1;
		m.irq_line       = irq_flag;
		return m;
	endfunction

	task automatic check_field(string field, logic [8:0] want_v, logic [8:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		cbm_result_t got;
		cbm_result_t want;
		if (!arst_n) begin
			chr_units   = 8'd0;
			prg_units   = PRG_UNITS_RESET;
			chr_banks   = '{default: 8'd0};
			prg_windows = '{default: 8'd0};
			irq_armed   = 1'b0;
			line_count  = 4'd0;
			irq_flag    = 1'b0;
			mappings_due.delete();
			mappings_due_count = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_CHR_ROM_UNITS)
					chr_units = cfg_data;
				else
					prg_units = cfg_data;
			end
			// retire the result first: it can only belong to an earlier item
			if (res.valid && res.ready) begin
				got = res.payload;
				if (mappings_due.size() == 0) begin
					$display("%0t: unexpected result item, expected none, got %h", $time, got);
					fail_count++;
				end else begin
					want = mappings_due.pop_front();
					check_field("chr_page_slot0", want.chr_page_slot0, got.chr_page_slot0);
					check_field("chr_page_slot1", want.chr_page_slot1, got.chr_page_slot1);
					check_field("chr_page_slot2", want.chr_page_slot2, got.chr_page_slot2);
					check_field("chr_page_slot3", want.chr_page_slot3, got.chr_page_slot3);
					check_field("prg_page_8000", 9'(want.prg_page_8000), 9'(got.prg_page_8000));
					check_field("prg_page_a000", 9'(want.prg_page_a000), 9'(got.prg_page_a000));
					check_field("prg_page_c000", want.prg_page_c000, got.prg_page_c000);
					check_field("prg_page_e000", want.prg_page_e000, got.prg_page_e000);
					check_field("irq_line", 9'(want.irq_line), 9'(got.irq_line));
				end
			end
			if (cmd.valid && cmd.ready)
				mappings_due.push_back(next_mapping(cmd.payload));
			mappings_due_count = mappings_due.size();
		end
	end

endmodule

/* test/cartridge_bank_mapper_scanline_irq_test.sv */
`timescale 1ns / 1ps
// Stimulus and verdict for the cartridge bank mapper with scanline IRQ.
module cartridge_bank_mapper_scanline_irq_test;
	import cbm_pkg::*;

	localparam int IRQ_LINES   = 8;
	localparam int PHASE_ITEMS = 100;
	localparam int PHASES      = 5;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_index;
	logic [7:0] cfg_data;

	int fail_count;
	int mappings_due;
	int items_sent;
	int ticks_sent;
	int settings_run;
	int burst_left;
	int stall_tick;
	int stall_mode;
	bit sending;

	cbm_item_if   cmd_ch ();
	cbm_result_if res_ch ();

	cartridge_bank_mapper_scanline_irq #(
		.IRQ_LINE_COUNT(IRQ_LINES)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_ch),
		.res      (res_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	cartridge_bank_mapper_scanline_irq_checker #(
		.IRQ_LINE_COUNT(IRQ_LINES)
	) mapping_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd_ch),
		.res               (res_ch),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.fail_count        (fail_count),
		.mappings_due_count(mappings_due)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("FAIL cartridge_bank_mapper_scanline_irq");
		$finish;
	end

	// Result side: switch between free flow, random and heavy stalls every so often
	always @(negedge clk) begin
		if (stall_tick % 96 == 0)
			stall_mode = $urandom_range(0, 3);
		stall_tick++;
		case (stall_mode)
			0: res_ch.ready <= 1'b1;
			1: res_ch.ready <= 1'($urandom_range(0, 1));
			2: res_ch.ready <= ($urandom_range(0, 4) == 0);
			default: res_ch.ready <= (stall_tick % 3 == 0);
		endcase
	end

	function automatic cbm_item_t cpu_write(logic [14:0] addr, logic [7:0] data);
		cbm_item_t it;
		it.operation   = OP_CPU_WRITE;
		it.cpu_address = addr;
		it.write_data  = data;
		return it;
	endfunction

	function automatic cbm_item_t scanline_tick();
		cbm_item_t it;
		it.operation   = OP_TICK;
		it.cpu_address = 15'($urandom);
		it.write_data  = 8'($urandom);
		return it;
	endfunction

	// Fill the address bits the decode ignores with random values
	function automatic logic [14:0] alias_of(logic [14:0] reg_addr);
		return reg_addr | (15'($urandom) & ~ADDR_MASK);
	endfunction

	function automatic cbm_item_t random_write();
		logic [14:0] reg_addr;
		case ($urandom_range(0, 7))
			0: reg_addr = ADDR_CHR0;
			1: reg_addr = ADDR_CHR1;
			2: reg_addr = ADDR_CHR2;
			3: reg_addr = ADDR_CHR3;
			4: reg_addr = ADDR_PRG0;
			5: reg_addr = ADDR_PRG1;
			6: reg_addr = ADDR_IRQ_ACK;
			default: reg_addr = ADDR_IRQ_EN;
		endcase
		return cpu_write(alias_of(reg_addr), 8'($urandom));
	endfunction

	function automatic cbm_item_t random_item();
		int pick;
		pick = $urandom_range(0, 99);
		// noise: any operation at any address, mostly outside the register space
		if (pick < 12)
			return cbm_item_t'(24'($urandom));
		if (pick < 50)
			return scanline_tick();
		return random_write();
	endfunction

	// Present one item and hold it until taken; bursts end in a random gap
	task automatic send_item(input cbm_item_t it);
		int gap;
		cmd_ch.valid   <= 1'b1;
		cmd_ch.payload <= it;
		sending = 1'b1;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		@(negedge clk);
		items_sent++;
		if (it.operation == OP_TICK)
			ticks_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 16);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				cmd_ch.valid <= 1'b0;
				sending = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	task automatic drain();
		if (sending) begin
			cmd_ch.valid <= 1'b0;
			sending = 1'b0;
		end
		while (mappings_due != 0)
			@(negedge clk);
	endtask

	task automatic set_sizes(input logic [7:0] chr_units, input logic [7:0] prg_units);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_CHR_ROM_UNITS;
		cfg_data  <= chr_units;
		@(negedge clk);
		cfg_index <= CFG_PRG_ROM_UNITS;
		cfg_data  <= prg_units;
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_run++;
	endtask

	// Enable, tick to near or past the end of the count, maybe re-enable, then mostly acknowledge
	task automatic irq_sequence();
		int lines;
		lines = $urandom_range(IRQ_LINES - 3, IRQ_LINES + 4);
		send_item(cpu_write(alias_of(ADDR_IRQ_EN), 8'($urandom)));
		repeat (lines) begin
			if ($urandom_range(0, 3) == 0)
				send_item(random_write());
			send_item(scanline_tick());
		end
		if ($urandom_range(0, 1) == 1)
			send_item(cpu_write(alias_of(ADDR_IRQ_EN), 8'($urandom)));
		send_item(scanline_tick());
		if ($urandom_range(0, 3) != 0)
			send_item(cpu_write(alias_of(ADDR_IRQ_ACK), 8'($urandom)));
	endtask

	initial begin
		int phase_start;
		cmd_ch.valid   = 1'b0;
		cmd_ch.payload = '0;
		res_ch.ready   = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = CFG_CHR_ROM_UNITS;
		cfg_data       = 8'd0;
		arst_n         = 1'b0;
		burst_left     = 1;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: reset sizes, CHR RAM mode
		send_item(cpu_write(15'h7FFF, 8'hFF));
		send_item(cpu_write(15'h7FFF, 8'hFF) ^ {OP_TICK, 23'd0});
		send_item(cpu_write(ADDR_CHR0, 8'h00));
		send_item(cpu_write(ADDR_CHR1 | ~ADDR_MASK, 8'hFF));
		send_item(cpu_write(ADDR_CHR2, 8'h55));
		send_item(cpu_write(ADDR_CHR3, 8'hAA));
		send_item(cpu_write(ADDR_PRG0 | ~ADDR_MASK, 8'hFF));
		send_item(cpu_write(ADDR_PRG1, 8'h80));
		// unmapped addresses, one of them with the acknowledge low bits below the space
		send_item(cpu_write(15'h0000, 8'hFF));
		send_item(cpu_write(15'h5FFF, 8'hFF));
		send_item(cpu_write(15'h1002, 8'h00));
		send_item(cpu_write(ADDR_IRQ_EN, 8'h00));
		repeat (IRQ_LINES + 1) send_item(scanline_tick());
		send_item(cpu_write(ADDR_IRQ_EN | ~ADDR_MASK, 8'hFF));
		send_item(scanline_tick());
		send_item(cpu_write(ADDR_IRQ_ACK, 8'h00));
		send_item(scanline_tick());
		drain();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: set_sizes(8'd1, 8'd1);
				1: set_sizes(8'd255, 8'd255);
				2: set_sizes(8'd0, 8'd0);
				3: set_sizes(8'($urandom_range(2, 254)), 8'($urandom_range(2, 254)));
				default: set_sizes(8'd4, 8'd128);
			endcase
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				if ($urandom_range(0, 5) == 0)
					irq_sequence();
				else
					send_item(random_item());
			end
			drain();
		end

		repeat (10) @(posedge clk);
		$display("Run covered %0d items (%0d scanline ticks) over %0d size settings",
			items_sent, ticks_sent, settings_run + 1);
		$display("including bank writes, IRQ enable and acknowledge, and unmapped addresses");
		if (fail_count == 0)
			$display("PASS cartridge_bank_mapper_scanline_irq");
		else
			$display("FAIL cartridge_bank_mapper_scanline_irq");
		$finish;
	end

endmodule
